>>> rtl/sbht_pkg.sv
// Shared types and constants of the scoreboard hazard tracker.
`timescale 1ns / 1ps
package sbht_pkg;

  // Sizes
  localparam int NUM_ARCH_REGS = 32;
  localparam int NUM_UNITS     = 5;
  localparam int REG_W         = 5;
  localparam int UNIT_W        = 3;
  localparam int TAG_W         = 3;
  localparam int LAT_W         = 4;
  localparam int MASK_W        = 5;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ISSUE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_TICK  = 2'd2,
    REQ_WRITE = 2'd3
  } req_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_INT_LAT = 2'd0,
    CFG_MEM_LAT = 2'd1,
    CFG_MUL_LAT = 2'd2,
    CFG_DIV_LAT = 2'd3
  } cfg_idx_t;

  // Functional unit numbers
  localparam logic [UNIT_W-1:0] UNIT_INT  = 3'd0;
  localparam logic [UNIT_W-1:0] UNIT_MUL1 = 3'd1;
  localparam logic [UNIT_W-1:0] UNIT_MUL2 = 3'd2;
  localparam logic [UNIT_W-1:0] UNIT_DIV  = 3'd3;
  localparam logic [UNIT_W-1:0] UNIT_MEM  = 3'd4;

  // Opcode decode
  localparam logic [6:0] OPC_OP      = 7'h33;
  localparam logic [6:0] OPC_LOAD    = 7'h03;
  localparam logic [6:0] OPC_STORE   = 7'h23;
  localparam logic [6:0] F7_MULDIV   = 7'h01;
  localparam logic [2:0] F3_MUL_LAST = 3'd3;

  // Latency reset values
  localparam logic [LAT_W-1:0] INT_LAT_RST = 4'd1;
  localparam logic [LAT_W-1:0] MEM_LAT_RST = 4'd2;
  localparam logic [LAT_W-1:0] MUL_LAT_RST = 4'd4;
  localparam logic [LAT_W-1:0] DIV_LAT_RST = 4'd10;

  // Request word
  typedef struct packed {
    req_t              req_type;
    logic [6:0]        opcode;
    logic [2:0]        funct3;
    logic [6:0]        funct7;
    logic [REG_W-1:0]  dest_reg;
    logic [REG_W-1:0]  src1_reg;
    logic [REG_W-1:0]  src2_reg;
    logic [UNIT_W-1:0] unit_sel;
  } in_t;

  // Result word
  typedef struct packed {
    logic              accepted;
    logic [UNIT_W-1:0] issued_unit;
    logic [MASK_W-1:0] busy_mask;
    logic [MASK_W-1:0] ready_mask;
    logic [MASK_W-1:0] finished_mask;
    logic [MASK_W-1:0] writable_mask;
  } out_t;

  // Latency settings
  typedef struct packed {
    logic [LAT_W-1:0] int_lat;
    logic [LAT_W-1:0] mem_lat;
    logic [LAT_W-1:0] mul_lat;
    logic [LAT_W-1:0] div_lat;
  } lat_t;

  // Register index names a real architectural register
  function automatic logic real_reg(input logic [REG_W-1:0] r);
    return (r != '0) && (int'(r) < NUM_ARCH_REGS);
  endfunction

endpackage

>>> rtl/sbht_core.sv
// Unit status table with the issue, read, tick and write logic.
`timescale 1ns / 1ps
module sbht_core
  import sbht_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  in_t  word,
  input  lat_t lat,
  output out_t result
);

  typedef struct packed {
    logic             busy;
    logic [REG_W-1:0] dest;
    logic [REG_W-1:0] src1;
    logic [REG_W-1:0] src2;
    logic [TAG_W-1:0] wait1;
    logic [TAG_W-1:0] wait2;
    logic             ready1;
    logic             ready2;
    logic [LAT_W-1:0] countdown;
  } unit_t;

  unit_t units      [NUM_UNITS];
  unit_t units_next [NUM_UNITS];

  // Units with no WAR hazard on their destination
  function automatic logic [NUM_UNITS-1:0] war_free_mask(input unit_t us [NUM_UNITS]);
    logic [NUM_UNITS-1:0] m;
    m = '1;
    for (int u = 0; u < NUM_UNITS; u++) begin
      for (int v = 0; v < NUM_UNITS; v++) begin
        if (real_reg(us[u].dest) && v != u && us[v].busy &&
            ((us[v].src1 == us[u].dest && us[v].ready1) ||
             (us[v].src2 == us[u].dest && us[v].ready2))) begin
          m[u] = 1'b0;
        end
      end
    end
    return m;
  endfunction

  logic [NUM_UNITS-1:0] busy_vec;
  logic [NUM_UNITS-1:0] war_cur;
  logic [NUM_UNITS-1:0] war_new;
  logic                 is_muldiv;
  logic [UNIT_W-1:0]    cand1;
  logic [UNIT_W-1:0]    cand2;
  logic [LAT_W-1:0]     issue_lat;
  logic [UNIT_W-1:0]    pick;
  logic                 pick_ok;
  logic                 waw;
  logic [TAG_W-1:0]     wait1;
  logic [TAG_W-1:0]     wait2;
  logic                 issue_ok;
  logic                 sel_ok;
  logic [UNIT_W-1:0]    sel;
  logic [TAG_W-1:0]     sel_tag;
  logic                 read_ok;
  logic                 write_ok;
  logic                 acc;
  logic [UNIT_W-1:0]    issued;

  // Busy flags and WAR status before the step
  always_comb begin
    for (int u = 0; u < NUM_UNITS; u++) begin
      busy_vec[u] = units[u].busy;
    end
    war_cur = war_free_mask(units);
  end

  // Classify the opcode into a unit class
  always_comb begin
    is_muldiv = (word.opcode == OPC_OP) && (word.funct7 == F7_MULDIV);
    priority if (is_muldiv && word.funct3 <= F3_MUL_LAST) begin
      cand1     = UNIT_MUL1;
      cand2     = UNIT_MUL2;
      issue_lat = lat.mul_lat;
    end else if (is_muldiv) begin
      cand1     = UNIT_DIV;
      cand2     = UNIT_DIV;
      issue_lat = lat.div_lat;
    end else if (word.opcode == OPC_LOAD || word.opcode == OPC_STORE) begin
      cand1     = UNIT_MEM;
      cand2     = UNIT_MEM;
      issue_lat = lat.mem_lat;
    end else begin
      cand1     = UNIT_INT;
      cand2     = UNIT_INT;
      issue_lat = lat.int_lat;
    end
  end

  // Free unit choice, WAW check and producer lookup for the sources
  always_comb begin
    pick_ok = 1'b1;
    pick    = cand1;
    if (busy_vec[cand1]) begin
      pick    = cand2;
      pick_ok = !busy_vec[cand2];
    end
    waw   = 1'b0;
    wait1 = '0;
    wait2 = '0;
    for (int v = 0; v < NUM_UNITS; v++) begin
      if (units[v].busy && real_reg(word.dest_reg) && units[v].dest == word.dest_reg) begin
        waw = 1'b1;
      end
      if (units[v].busy && real_reg(word.src1_reg) && units[v].dest == word.src1_reg) begin
        wait1 = TAG_W'(v + 1);
      end
      if (units[v].busy && real_reg(word.src2_reg) && units[v].dest == word.src2_reg) begin
        wait2 = TAG_W'(v + 1);
      end
    end
    issue_ok = pick_ok && !waw;
  end

  // Read and write guards on the selected unit
  always_comb begin
    sel_ok   = word.unit_sel < UNIT_W'(NUM_UNITS);
    sel      = sel_ok ? word.unit_sel : UNIT_INT;
    sel_tag  = TAG_W'(sel) + TAG_W'(1);
    read_ok  = sel_ok && units[sel].busy && units[sel].ready1 && units[sel].ready2;
    write_ok = sel_ok && units[sel].busy && (units[sel].countdown == '0) && war_cur[sel];
  end

  // Next table contents
  always_comb begin
    units_next = units;
    acc        = 1'b0;
    issued     = UNIT_INT;
    unique case (word.req_type)
      REQ_ISSUE: begin
        if (issue_ok) begin
          units_next[pick].busy      = 1'b1;
          units_next[pick].dest      = word.dest_reg;
          units_next[pick].src1      = word.src1_reg;
          units_next[pick].src2      = word.src2_reg;
          units_next[pick].wait1     = wait1;
          units_next[pick].wait2     = wait2;
          units_next[pick].ready1    = (wait1 == '0);
          units_next[pick].ready2    = (wait2 == '0);
          units_next[pick].countdown = issue_lat;
          acc                        = 1'b1;
          issued                     = pick;
        end
      end
      REQ_READ: begin
        if (read_ok) begin
          units_next[sel].ready1 = 1'b0;
          units_next[sel].ready2 = 1'b0;
          acc                    = 1'b1;
        end
      end
      REQ_TICK: begin
        for (int u = 0; u < NUM_UNITS; u++) begin
          if (units[u].busy && !units[u].ready1 && !units[u].ready2 &&
              units[u].wait1 == '0 && units[u].wait2 == '0 &&
              units[u].countdown != '0) begin
            units_next[u].countdown = units[u].countdown - LAT_W'(1);
          end
        end
      end
      REQ_WRITE: begin
        if (write_ok) begin
          // broadcast: wake everything waiting on this unit
          for (int v = 0; v < NUM_UNITS; v++) begin
            if (units[v].busy && units[v].wait1 == sel_tag) begin
              units_next[v].wait1  = '0;
              units_next[v].ready1 = 1'b1;
            end
            if (units[v].busy && units[v].wait2 == sel_tag) begin
              units_next[v].wait2  = '0;
              units_next[v].ready2 = 1'b1;
            end
          end
          units_next[sel] = '0;
          acc             = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Status masks after the step
  always_comb begin
    war_new              = war_free_mask(units_next);
    result.accepted      = acc;
    result.issued_unit   = issued;
    result.writable_mask = war_new;
    for (int u = 0; u < NUM_UNITS; u++) begin
      result.busy_mask[u]     = units_next[u].busy;
      result.ready_mask[u]    = units_next[u].busy && units_next[u].ready1 &&
                                units_next[u].ready2 && units_next[u].countdown != '0;
      result.finished_mask[u] = units_next[u].busy && units_next[u].countdown == '0;
    end
  end

  // Table registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int u = 0; u < NUM_UNITS; u++) begin
        units[u] <= '0;
      end
    end else if (step) begin
      units <= units_next;
    end
  end

endmodule

>>> rtl/scoreboard_hazard_tracker.sv
// Top level of the scoreboard hazard tracker: handshake, latency registers.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   in_t  (command and instruction fields)
//   rsp      out        rsp_valid/rsp_stall   out_t (acceptance and unit masks)
//   cfg      in         cfg_we                cfg_index, cfg_data (latencies)
//
// One word per cycle while rsp_stall does not hold the result; each request passes
// the input register, then the table update and the result register.
// The unit table updates as a word leaves the input register, so each word
// sees the state left by the one before.
// Synchronous reset clears the table, both valids and loads default latencies.
// A stalled result holds; the input register still takes a word while it is empty.
`timescale 1ns / 1ps
module scoreboard_hazard_tracker
  import sbht_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  in_t              req_word,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output out_t             rsp_word,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [LAT_W-1:0] cfg_data
);

  logic s1_valid;
  in_t  s1_word;
  lat_t lat;
  out_t result;
  logic advance;

  // Handshake control
  assign advance   = s1_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = s1_valid && !advance;

  sbht_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .word   (s1_word),
    .lat    (lat),
    .result (result)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
    if (req_valid && !req_stall) begin
      s1_word <= req_word;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (!rsp_valid || !rsp_stall) begin
      rsp_valid <= s1_valid;
    end
    if (advance) begin
      rsp_word <= result;
    end
  end

  // Latency registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lat.int_lat <= INT_LAT_RST;
      lat.mem_lat <= MEM_LAT_RST;
      lat.mul_lat <= MUL_LAT_RST;
      lat.div_lat <= DIV_LAT_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_INT_LAT: lat.int_lat <= cfg_data;
        CFG_MEM_LAT: lat.mem_lat <= cfg_data;
        CFG_MUL_LAT: lat.mul_lat <= cfg_data;
        CFG_DIV_LAT: lat.div_lat <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule
